[rtl/core/hufd_pkg.sv]
// Shared types and constants for the Huffman tree load and decode block.
package hufd_pkg;

   localparam int SYM_BITS = 8;   // bits per leaf symbol
   localparam int NODE_W   = 9;   // node index width, covers up to 511 nodes
   localparam int CNT_W    = 32;  // symbol count width

   localparam logic ST_OK    = 1'b0;
   localparam logic ST_ERROR = 1'b1;

   typedef enum logic [3:0] {
      PH_TREE   = 4'b0001,
      PH_LEAF   = 4'b0010,
      PH_DECODE = 4'b0100,
      PH_IDLE   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic bit_req;
      logic first;
   } req_type;

   typedef struct packed {
      logic [SYM_BITS-1:0] symbol;
      logic                last;
      logic                status;
   } rsp_type;

   // one parent stack entry: left-filled flag and node index
   typedef struct packed {
      logic              filled;
      logic [NODE_W-1:0] node;
   } stack_entry_type;

   typedef struct packed {
      logic              clear;
      logic              set_flag;
      logic              pop;
      logic              push;
      logic [NODE_W-1:0] node;
   } stack_op_type;

   typedef struct packed {
      logic                link_en;
      logic                link_right;
      logic [NODE_W-1:0]   link_addr;
      logic [NODE_W-1:0]   link_data;
      logic                leaf_en;
      logic [NODE_W-1:0]   leaf_addr;
      logic                leaf_is_leaf;
      logic [SYM_BITS-1:0] leaf_symbol;
   } node_wr_type;

   typedef struct packed {
      logic [NODE_W-1:0]   left;
      logic [NODE_W-1:0]   right;
      logic                is_leaf;
      logic [SYM_BITS-1:0] symbol;
   } node_rd_type;

endpackage

[rtl/core/hufd_node_tab.sv]
// Node table: child links and leaf records, a link write port, a leaf write port and one registered read port.
module hufd_node_tab #(
   parameter int DEPTH = 511
) (
   input  logic                 clock,
   input  hufd_pkg::node_wr_type wr,
   input  logic                 rd_en,
   input  logic [hufd_pkg::NODE_W-1:0] rd_addr,
   output hufd_pkg::node_rd_type rd
);
   import hufd_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic [NODE_W-1:0]        left_mem  [DEPTH];
   logic [NODE_W-1:0]        right_mem [DEPTH];
   logic [SYM_BITS:0]        leaf_mem  [DEPTH];

   logic [NODE_W-1:0]        rd_left_ff;
   logic [NODE_W-1:0]        rd_right_ff;
   logic [SYM_BITS:0]        rd_leaf_ff;

   always_ff @(posedge clock) begin
      if (wr.link_en && !wr.link_right) begin
         left_mem[wr.link_addr[AW-1:0]] <= wr.link_data;
      end
      if (wr.link_en && wr.link_right) begin
         right_mem[wr.link_addr[AW-1:0]] <= wr.link_data;
      end
      if (wr.leaf_en) begin
         leaf_mem[wr.leaf_addr[AW-1:0]] <= {wr.leaf_is_leaf, wr.leaf_symbol};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_left_ff  <= left_mem[rd_addr[AW-1:0]];
         rd_right_ff <= right_mem[rd_addr[AW-1:0]];
         rd_leaf_ff  <= leaf_mem[rd_addr[AW-1:0]];
      end
   end

   assign rd.left    = rd_left_ff;
   assign rd.right   = rd_right_ff;
   assign rd.is_leaf = rd_leaf_ff[SYM_BITS];
   assign rd.symbol  = rd_leaf_ff[SYM_BITS-1:0];

endmodule

[rtl/core/hufd_stack.sv]
// Parent stack: top entry in flops, lower entries in a memory; the top is refilled from it after a pop.
module hufd_stack #(
   parameter int SYMBOLS = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hufd_pkg::stack_op_type        op,
   output hufd_pkg::stack_entry_type     top,
   output logic [$clog2(SYMBOLS+1)-1:0]  depth
);
   import hufd_pkg::*;

   localparam int DW  = $clog2(SYMBOLS + 1);
   localparam int SAW = $clog2(SYMBOLS);

   stack_entry_type stack_mem [SYMBOLS];

   stack_entry_type top_ff, top_in;
   stack_entry_type rd_ff;
   logic [DW-1:0]   depth_ff, depth_in;
   logic            load_ff, load_in;
   logic [DW-1:0]   d_eff, d_m1, d_m2;
   logic            wr_en, rd_en;

   always_comb begin
      d_eff    = op.clear ? '0 : depth_ff;
      d_m1     = d_eff - DW'(1);
      d_m2     = d_eff - DW'(2);
      depth_in = d_eff;
      top_in   = (load_ff && !op.clear) ? rd_ff : top_ff;
      load_in  = 1'b0;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      if (op.push) begin
         top_in.filled = 1'b0;
         top_in.node   = op.node;
         if (op.set_flag) begin
            // old top, now left-filled, moves down into the memory
            wr_en    = 1'b1;
            depth_in = d_eff + DW'(1);
         end else if (!op.pop) begin
            depth_in = d_eff + DW'(1);
         end
      end else if (op.set_flag) begin
         top_in.filled = 1'b1;
      end else if (op.pop) begin
         depth_in = d_m1;
         if (d_eff > DW'(1)) begin
            rd_en   = 1'b1;
            load_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[d_m1[SAW-1:0]] <= '{filled: 1'b1, node: top_ff.node};
      end
      if (rd_en) begin
         rd_ff <= stack_mem[d_m2[SAW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (reset) begin
         depth_ff <= '0;
         load_ff  <= 1'b0;
      end else begin
         depth_ff <= depth_in;
         load_ff  <= load_in;
      end
   end

   assign top   = top_ff;
   assign depth = depth_ff;

endmodule

[rtl/core/hufd_out_fifo.sv]
// Two-entry result queue in front of the rsp channel.
module hufd_out_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hufd_pkg::rsp_type push_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hufd_pkg::rsp_type rsp_data,
   output logic [1:0]        count
);
   import hufd_pkg::*;

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign count_in  = count_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
   end

endmodule

[rtl/core/huffman_tree_load_and_decode.sv]
// Huffman decoder top level: pre-order tree rebuild followed by bit-serial decode.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  req     | in        | req_valid/req_stall  | req_data  {bit_req, first}
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_data  {symbol, last, status}
//  csr     | in        | csr_wr_en            | csr_wr_data  symbol_count (32 bit)
//
//  One compressed bit per cycle in every phase while req_stall is low.
//  A decoded symbol reaches rsp through the registered node read and then the
//  two-entry result queue; an error goes through its registered flag and the queue.
//  Reset (synchronous) clears control only; node table and stack memory hold junk
//  until written, so no clearing pass is needed and req is taken right after reset.
//  req_stall rises when the queue could not hold the in-flight results and a new one.
module huffman_tree_load_and_decode #(
   parameter int SYMBOLS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hufd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hufd_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [hufd_pkg::CNT_W-1:0] csr_wr_data
);
   import hufd_pkg::*;

   localparam int NODE_MAX = 2 * SYMBOLS - 1;
   localparam int DW       = $clog2(SYMBOLS + 1);
   localparam int NU_W     = NODE_W + 1;
   localparam int SC_W     = $clog2(SYM_BITS);

   // control state
   phase_type           phase_ff, phase_in, ph_now;
   logic [NU_W-1:0]     nodes_ff, nodes_in;
   logic [SYM_BITS-1:0] shift_ff, shift_in, shift_nx;
   logic [SC_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]    symbols_left_ff, symbols_left_in, left_r;
   logic [CNT_W-1:0]    symbol_count_ff;
   logic                pend_ff, pend_in;   // node read in flight for a decode bit
   logic                err_ff, err_in;     // error result in flight

   // payload state
   logic [NODE_W-1:0]   leaf_node_ff, leaf_node_in;
   logic [NODE_W-1:0]   root_left_ff, root_left_in;
   logic [NODE_W-1:0]   root_right_ff, root_right_in;
   logic [NODE_W-1:0]   cur_left_ff, cur_left_in;
   logic [NODE_W-1:0]   cur_right_ff, cur_right_in;

   logic                acc, pop, bit_v, tree_err, res_leaf, res_last, res_valid;
   logic [1:0]          fifo_count, cnt_after;
   logic [NU_W-1:0]     n;
   logic [NODE_W-1:0]   eff_left, eff_right, nxt;
   logic [DW-1:0]       d_eff;
   rsp_type             res_data;

   node_wr_type         node_wr;
   node_rd_type         node_rd;
   logic                node_rd_en;
   logic [NODE_W-1:0]   node_rd_addr;
   stack_op_type        sop;
   stack_entry_type     stack_top;
   logic [DW-1:0]       stack_depth;

   // ---------------------------------------------------------------- flow control
   // Room is reserved for the one result that may still come from the stage in flight.
   assign pop       = rsp_valid && !rsp_stall;
   assign cnt_after = fifo_count - 2'(pop);
   assign req_stall = (cnt_after == 2'd2) || ((cnt_after == 2'd1) && (pend_ff || err_ff));
   assign acc       = req_valid && !req_stall;
   assign bit_v     = req_data.bit_req;

   // ---------------------------------------------------------------- resolution
   // The node read issued by last cycle's decode bit lands now: a leaf yields a symbol
   // and the walk goes back to the root, otherwise the fetched node becomes current.
   assign res_leaf  = pend_ff && node_rd.is_leaf;
   assign res_last  = (symbols_left_ff == CNT_W'(1));
   assign res_valid = err_ff || res_leaf;

   always_comb begin
      if (err_ff) begin
         res_data.symbol = '0;
         res_data.last   = 1'b1;
         res_data.status = ST_ERROR;
      end else begin
         res_data.symbol = node_rd.symbol;
         res_data.last   = res_last;
         res_data.status = ST_OK;
      end
   end

   always_comb begin
      if (pend_ff && node_rd.is_leaf) begin
         eff_left  = root_left_ff;
         eff_right = root_right_ff;
      end else if (pend_ff) begin
         eff_left  = node_rd.left;
         eff_right = node_rd.right;
      end else begin
         eff_left  = cur_left_ff;
         eff_right = cur_right_ff;
      end
   end

   assign left_r = symbols_left_ff -
                   CNT_W'(res_leaf && (symbols_left_ff != '0));

   // ---------------------------------------------------------------- next state
   always_comb begin
      phase_in        = phase_ff;
      if (res_leaf && (left_r == '0)) phase_in = PH_IDLE;
      symbols_left_in = left_r;
      nodes_in        = nodes_ff;
      shift_in        = shift_ff;
      cnt_in          = cnt_ff;
      leaf_node_in    = leaf_node_ff;
      root_left_in    = root_left_ff;
      root_right_in   = root_right_ff;
      cur_left_in     = eff_left;
      cur_right_in    = eff_right;
      pend_in         = 1'b0;
      err_in          = 1'b0;
      node_wr         = '0;
      node_rd_en      = 1'b0;
      node_rd_addr    = '0;
      sop             = '0;
      d_eff           = stack_depth;
      tree_err        = 1'b0;
      shift_nx        = '0;
      nxt             = '0;

      // first bit of a new stream: drop any parse in progress
      if (acc && req_data.first) begin
         phase_in        = PH_TREE;
         nodes_in        = '0;
         shift_in        = '0;
         cnt_in          = '0;
         symbols_left_in = '0;
         sop.clear       = 1'b1;
         d_eff           = '0;
      end

      ph_now = phase_in;
      n      = nodes_in;

      if (acc) begin
         case (ph_now)
            PH_TREE: begin
               tree_err = (bit_v && (n == '0)) || (n >= NU_W'(NODE_MAX)) ||
                          (!bit_v && (d_eff >= DW'(SYMBOLS)) && !stack_top.filled);
               if (tree_err) begin
                  err_in   = 1'b1;
                  phase_in = PH_IDLE;
               end else begin
                  // hang the new node under the open parent on top of the stack
                  if (d_eff != '0) begin
                     node_wr.link_en    = 1'b1;
                     node_wr.link_addr  = stack_top.node;
                     node_wr.link_data  = n[NODE_W-1:0];
                     node_wr.link_right = stack_top.filled;
                     if (!stack_top.filled) begin
                        sop.set_flag = 1'b1;
                        if (stack_top.node == '0) root_left_in = n[NODE_W-1:0];
                     end else begin
                        sop.pop = 1'b1;
                        if (stack_top.node == '0) root_right_in = n[NODE_W-1:0];
                     end
                  end
                  nodes_in             = n + NU_W'(1);
                  node_wr.leaf_en      = 1'b1;
                  node_wr.leaf_addr    = n[NODE_W-1:0];
                  node_wr.leaf_is_leaf = bit_v;
                  if (!bit_v) begin
                     sop.push = 1'b1;
                     sop.node = n[NODE_W-1:0];
                  end else begin
                     leaf_node_in = n[NODE_W-1:0];
                     shift_in     = '0;
                     cnt_in       = '0;
                     phase_in     = PH_LEAF;
                  end
               end
            end
            PH_LEAF: begin
               shift_nx = {shift_ff[SYM_BITS-2:0], bit_v};
               shift_in = shift_nx;
               if (cnt_ff == SC_W'(SYM_BITS - 1)) begin
                  node_wr.leaf_en      = 1'b1;
                  node_wr.leaf_addr    = leaf_node_ff;
                  node_wr.leaf_is_leaf = 1'b1;
                  node_wr.leaf_symbol  = shift_nx;
                  cnt_in               = '0;
                  if (stack_depth == '0) begin
                     // tree complete: start the walk at the root
                     cur_left_in     = root_left_ff;
                     cur_right_in    = root_right_ff;
                     symbols_left_in = symbol_count_ff;
                     phase_in        = (symbol_count_ff == '0) ? PH_IDLE : PH_DECODE;
                  end else begin
                     phase_in = PH_TREE;
                  end
               end else begin
                  cnt_in = cnt_ff + SC_W'(1);
               end
            end
            PH_DECODE: begin
               nxt = bit_v ? eff_right : eff_left;
               if (nxt >= NODE_W'(NODE_MAX)) nxt = '0;
               node_rd_en   = 1'b1;
               node_rd_addr = nxt;
               pend_in      = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      leaf_node_ff  <= leaf_node_in;
      root_left_ff  <= root_left_in;
      root_right_ff <= root_right_in;
      cur_left_ff   <= cur_left_in;
      cur_right_ff  <= cur_right_in;
      if (reset) begin
         phase_ff        <= PH_TREE;
         nodes_ff        <= '0;
         shift_ff        <= '0;
         cnt_ff          <= '0;
         symbols_left_ff <= '0;
         symbol_count_ff <= CNT_W'(1);
         pend_ff         <= 1'b0;
         err_ff          <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         nodes_ff        <= nodes_in;
         shift_ff        <= shift_in;
         cnt_ff          <= cnt_in;
         symbols_left_ff <= symbols_left_in;
         pend_ff         <= pend_in;
         err_ff          <= err_in;
         if (csr_wr_en) symbol_count_ff <= csr_wr_data;
      end
   end

   // ---------------------------------------------------------------- sub-blocks
   hufd_node_tab #(
      .DEPTH (NODE_MAX)
   ) u_node_tab (
      .clock   (clock),
      .wr      (node_wr),
      .rd_en   (node_rd_en),
      .rd_addr (node_rd_addr),
      .rd      (node_rd)
   );

   hufd_stack #(
      .SYMBOLS (SYMBOLS)
   ) u_stack (
      .clock (clock),
      .reset (reset),
      .op    (sop),
      .top   (stack_top),
      .depth (stack_depth)
   );

   hufd_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .count     (fifo_count)
   );

endmodule
